// ===== src/salc_pkg.sv =====
// shared types, constants and helpers for the set-associative lru cache model
`timescale 1ns / 1ps
package salc_pkg;

  localparam int STAMP_W     = 64;
  localparam int CNT_W       = 32;
  localparam int OUTCOME_W   = 2;
  localparam int WAY_USED_W  = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int OUT_FIELD_W = OUTCOME_W + WAY_USED_W + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

  // access outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // set search status handed from the compare unit to the sequencer
  typedef struct packed {
    logic hit;
    logic have_empty;
  } scan_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// ===== src/set_assoc_lru_cache_model.sv =====
// top level: set-associative lru cache hit/miss model with clearing pass and sequencer
// flow: an accepted request scans n ways (ways_in_use, or up to and including the hit way),
//   then the update state registers the result, which any output stall can hold off
// a new request is taken only in idle, once the previous update is done; the scan is set by the single
//   ram read port that the shared compare unit scans one way per cycle
// reset: a clearing pass zeroes
//   every line before the first request is taken; config writes are taken throughout
`timescale 1ns / 1ps
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48,
  localparam int IN_TDATA_W  = ((ADDR_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata,   // address
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // outcome, way_used, hit_total, miss_total, eviction_total
  output logic [salc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import salc_pkg::*;

  localparam int NUM_LINES = (2 ** MAX_SET_BITS) * MAX_WAYS;
  localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ENTRY_W   = 1 + ADDR_WIDTH + STAMP_W;

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [3:0] set_bits_q, ways_q;
  logic [4:0] off_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 4'd4;
      ways_q     <= 4'd1;
      off_bits_q <= 5'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_BITS:    set_bits_q <= cfg_data_i[3:0];
        CFG_WAYS_IN_USE: ways_q     <= cfg_data_i[3:0];
        CFG_OFFSET_BITS: off_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [4:0]       s_eff;
  logic [5:0]       ways_eff;
  logic [WAY_W-1:0] last_way;

  always_comb begin
    s_eff = ({1'b0, set_bits_q} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, set_bits_q};
    if (ways_q == 4'd0) begin
      ways_eff = 6'd1;
    end else if ({2'b00, ways_q} > 6'(MAX_WAYS)) begin
      ways_eff = 6'(MAX_WAYS);
    end else begin
      ways_eff = {2'b00, ways_q};
    end
    last_way = WAY_W'(ways_eff - 6'd1);
  end

  // address split at accept: drop offset, take set bits, rest is the tag
  logic [ADDR_WIDTH-1:0] shifted, tag_d, tag_q;
  logic [SET_W-1:0]      set_d, set_q;

  always_comb begin
    shifted = s_axis_tdata[ADDR_WIDTH-1:0] >> off_bits_q;
    for (int j = 0; j < SET_W; j++) begin
      set_d[j] = shifted[j] & (5'(j) < s_eff);
    end
    tag_d = shifted >> s_eff;
  end

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  // way scan pointers: read issued for rd_way, compared in the next cycle as cmp_way
  logic [WAY_W-1:0]  rd_way_q, cmp_way_q;
  logic              cmp_vld_q;
  logic              issue_en;
  logic [LINE_W-1:0] base;

  assign issue_en = (state_q == ST_SCAN) && (rd_way_q <= last_way);
  assign base     = LINE_W'(set_q) * LINE_W'(MAX_WAYS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_way_q  <= '0;
      cmp_way_q <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= issue_en;
      cmp_way_q <= rd_way_q;
      if (accept) begin
        rd_way_q <= '0;
      end else if (issue_en) begin
        rd_way_q <= rd_way_q + 1'b1;
      end
    end
  end

  // line store: {valid, tag, stamp}
  logic [LINE_W-1:0]  clr_addr_q;
  logic               ram_we;
  logic [LINE_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // compare unit interface
  logic              cmp_feed, hit_now;
  scan_status_t      scan_st;
  logic [WAY_W-1:0]  hit_way, empty_way, old_way, way_sel;

  assign cmp_feed = cmp_vld_q && (state_q == ST_SCAN);

  salc_cmp #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .WAY_W      (WAY_W)
  ) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .vld_i       (cmp_feed),
    .way_i       (cmp_way_q),
    .ent_valid_i (ram_rdata[ENTRY_W-1]),
    .ent_tag_i   (ram_rdata[STAMP_W +: ADDR_WIDTH]),
    .ent_stamp_i (ram_rdata[STAMP_W-1:0]),
    .tag_i       (tag_q),
    .hit_now_o   (hit_now),
    .status_o    (scan_st),
    .hit_way_o   (hit_way),
    .empty_way_o (empty_way),
    .old_way_o   (old_way)
  );

  // hit wins, then the first empty way, else the lru way
  assign way_sel = scan_st.hit ? hit_way : (scan_st.have_empty ? empty_way : old_way);

  logic upd_go;
  assign upd_go = (state_q == ST_UPD) && (!m_axis_tvalid || m_axis_tready);

  // running clock and saturating counters
  logic [STAMP_W-1:0] clock_q;
  logic [CNT_W-1:0]   hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [CNT_W-1:0]   hit_cnt_d, miss_cnt_d, evict_cnt_d;
  logic [OUTCOME_W-1:0] outcome;

  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (scan_st.hit) begin
      outcome   = OUT_HIT;
      hit_cnt_d = sat_inc(hit_cnt_q);
    end else if (scan_st.have_empty) begin
      outcome    = OUT_FILL;
      miss_cnt_d = sat_inc(miss_cnt_q);
    end else begin
      outcome     = OUT_EVICT;
      miss_cnt_d  = sat_inc(miss_cnt_q);
      evict_cnt_d = sat_inc(evict_cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else if (upd_go) begin
      clock_q     <= clock_q + 1'b1;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
    end
  end

  // ram ports: clearing sweep or the single write of an update
  always_comb begin
    ram_raddr = base + LINE_W'(rd_way_q);
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_go;
      ram_waddr = base + LINE_W'(way_sel);
      ram_wdata = {1'b1, tag_q, clock_q};
    end
  end

  salc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_addr_q == LINE_W'(NUM_LINES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      // stop at the first hit or after the last way in use
      ST_SCAN:  if (cmp_feed && (hit_now || cmp_way_q == last_way)) state_d = ST_UPD;
      ST_UPD:   if (upd_go) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      out_data_q <= OUT_TDATA_W'({evict_cnt_d, miss_cnt_d, hit_cnt_d,
                                  WAY_USED_W'(way_sel), outcome});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during clearing pass");

  a_way_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |-> (way_sel <= last_way))
    else $error("selected way beyond ways in use");

  a_clock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> (clock_q == $past(clock_q) + 1'b1))
    else $error("access clock did not advance on update");

  a_hit_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_go && scan_st.hit) |=> (m_axis_tvalid && m_axis_tdata[OUTCOME_W-1:0] == OUT_HIT))
    else $error("hit not reported as hit");

endmodule

// ===== src/salc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/salc_cmp.sv =====
// shared compare unit: tag match, first empty way and oldest stamp tracking
`timescale 1ns / 1ps
module salc_cmp #(
  parameter int ADDR_WIDTH = 48,
  parameter int WAY_W = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          vld_i,
  input  logic [WAY_W-1:0]              way_i,
  input  logic                          ent_valid_i,
  input  logic [ADDR_WIDTH-1:0]         ent_tag_i,
  input  logic [salc_pkg::STAMP_W-1:0]  ent_stamp_i,
  input  logic [ADDR_WIDTH-1:0]         tag_i,
  output logic                          hit_now_o,
  output salc_pkg::scan_status_t        status_o,
  output logic [WAY_W-1:0]              hit_way_o,
  output logic [WAY_W-1:0]              empty_way_o,
  output logic [WAY_W-1:0]              old_way_o
);
  import salc_pkg::*;

  scan_status_t       st_q, st_d;
  logic [WAY_W-1:0]   hit_way_q, empty_way_q, old_way_q;
  logic [STAMP_W-1:0] old_stamp_q;
  logic               older;

  assign hit_now_o = vld_i && ent_valid_i && (ent_tag_i == tag_i);
  // first way seeds the search, later ways must be strictly older
  assign older     = (way_i == '0) || (ent_stamp_i < old_stamp_q);

  always_comb begin
    st_d = st_q;
    if (start_i) begin
      st_d = '0;
    end else if (vld_i) begin
      if (hit_now_o) begin
        st_d.hit = 1'b1;
      end else if (!ent_valid_i && !st_q.have_empty) begin
        st_d.have_empty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && !start_i) begin
      if (hit_now_o) begin
        hit_way_q <= way_i;
      end
      if (!ent_valid_i && !st_q.have_empty) begin
        empty_way_q <= way_i;
      end
      if (older) begin
        old_stamp_q <= ent_stamp_i;
        old_way_q   <= way_i;
      end
    end
  end

  assign status_o    = st_q;
  assign hit_way_o   = hit_way_q;
  assign empty_way_o = empty_way_q;
  assign old_way_o   = old_way_q;

endmodule
